>>> sv/macroman_to_utf8_transcoder_top_defines.svh
// Assertion macros shared by the transcoder checker.
// No dependencies; include by bare file name.
`ifndef MACROMAN_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH
`define MACROMAN_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MRU8_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define MRU8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mru8_pkg.sv
// Shared types, constants and the Mac OS Roman encode function.
// No dependencies; imported by every transcoder module.
package mru8_pkg;

  // Byte count codes of one queued word
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Upper half of Mac OS Roman, code points
  localparam logic [15:0] ROMAN_MAP [128] = '{
    16'h00c4, 16'h00c5, 16'h00c7, 16'h00c9, 16'h00d1, 16'h00d6, 16'h00dc, 16'h00e1,
    16'h00e0, 16'h00e2, 16'h00e4, 16'h00e3, 16'h00e5, 16'h00e7, 16'h00e9, 16'h00e8,
    16'h00ea, 16'h00eb, 16'h00ed, 16'h00ec, 16'h00ee, 16'h00ef, 16'h00f1, 16'h00f3,
    16'h00f2, 16'h00f4, 16'h00f6, 16'h00f5, 16'h00fa, 16'h00f9, 16'h00fb, 16'h00fc,
    16'h2020, 16'h00b0, 16'h00a2, 16'h00a3, 16'h00a7, 16'h2022, 16'h00b6, 16'h00df,
    16'h00ae, 16'h00a9, 16'h2122, 16'h00b4, 16'h00a8, 16'h2260, 16'h00c6, 16'h00d8,
    16'h221e, 16'h00b1, 16'h2264, 16'h2265, 16'h00a5, 16'h00b5, 16'h2202, 16'h2211,
    16'h220f, 16'h03c0, 16'h222b, 16'h00aa, 16'h00ba, 16'h2126, 16'h00e6, 16'h00f8,
    16'h00bf, 16'h00a1, 16'h00ac, 16'h221a, 16'h0192, 16'h2248, 16'h2206, 16'h00ab,
    16'h00bb, 16'h2026, 16'h00a0, 16'h00c0, 16'h00c3, 16'h00d5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201c, 16'h201d, 16'h2018, 16'h2019, 16'h00f7, 16'h25ca,
    16'h00ff, 16'h0178, 16'h2044, 16'h00a4, 16'h2039, 16'h203a, 16'hfb01, 16'hfb02,
    16'h2021, 16'h00b7, 16'h201a, 16'h201e, 16'h2030, 16'h00c2, 16'h00ca, 16'h00c1,
    16'h00cb, 16'h00c8, 16'h00cd, 16'h00ce, 16'h00cf, 16'h00cc, 16'h00d3, 16'h00d4,
    16'hf8ff, 16'h00d2, 16'h00da, 16'h00db, 16'h00d9, 16'h0131, 16'h02c6, 16'h02dc,
    16'h00af, 16'h02d8, 16'h02d9, 16'h02da, 16'h00b8, 16'h02dd, 16'h02db, 16'h02c7
  };

  // One classified character: its output bytes in order and their count
  typedef struct packed {
    logic [1:0]       nbytes;
    logic [2:0][7:0]  bytes;   // bytes[0] goes out first
    logic             eon;
  } mru8_word_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } mru8_qstat_t;

  function automatic mru8_word_t mru8_encode(input logic [7:0] b, input logic raw,
                                              input logic eon);
    logic [15:0] cp;
    mru8_word_t  w;
    cp = b[7] ? ROMAN_MAP[b[6:0]] : {8'h00, b};
    w.eon   = eon;
    w.bytes = '0;
    if (raw) begin
      w.nbytes   = LEN_ONE;
      w.bytes[0] = b;
    end else if (cp < 16'h0080) begin
      w.nbytes   = LEN_ONE;
      w.bytes[0] = cp[7:0];
    end else if (cp < 16'h0800) begin
      w.nbytes   = LEN_TWO;
      w.bytes[0] = {3'b110, cp[10:6]};
      w.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      w.nbytes   = LEN_THREE;
      w.bytes[0] = {4'b1110, cp[15:12]};
      w.bytes[1] = {2'b10, cp[11:6]};
      w.bytes[2] = {2'b10, cp[5:0]};
    end
    return w;
  endfunction

endpackage

>>> sv/mru8_front.sv
// Front end: takes input words and the raw-mode register, classifies each
// byte into a UTF-8 run, or a single raw byte in raw mode. Depends on mru8_pkg.
module mru8_front import mru8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_name_byte,
  input  logic        in_end_of_name,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_raw_mode,
  input  mru8_qstat_t qstat,
  output logic        push,
  output mru8_word_t  push_word
);

  logic raw_mode_r, raw_mode_nxt;

  assign cfg_ready    = 1'b1;
  assign raw_mode_nxt = (cfg_valid && cfg_ready) ? cfg_raw_mode : raw_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r <= 1'b0;
    end else begin
      raw_mode_r <= raw_mode_nxt;
    end
  end

  assign in_ready  = !qstat.full;
  assign push      = in_valid && in_ready;
  assign push_word = mru8_encode(in_name_byte, raw_mode_r, in_end_of_name);

endmodule

>>> sv/mru8_queue.sv
// Short word queue between front and back ends.
// Depends on mru8_pkg.
module mru8_queue import mru8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mru8_word_t  push_word,
  input  logic        pop,
  output mru8_word_t  head_word,
  output mru8_qstat_t qstat
);

  mru8_word_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head_word   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

>>> sv/mru8_back.sv
// Back end: walks the head word byte by byte into the output register.
// Depends on mru8_pkg.
module mru8_back import mru8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mru8_word_t  head_word,
  input  mru8_qstat_t qstat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_char,
  output logic        out_name_done
);

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       done_r, done_nxt;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = !qstat.empty && (!valid_r || out_ready);
  assign is_last = (idx_r == head_word.nbytes - 2'd1);
  assign pop     = load && is_last;

  always_comb begin
    unique case (idx_r)
      2'd0:    sel_byte = head_word.bytes[0];
      2'd1:    sel_byte = head_word.bytes[1];
      2'd2:    sel_byte = head_word.bytes[2];
      default: sel_byte = head_word.bytes[0];
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    done_nxt  = done_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = sel_byte;
      last_nxt  = is_last;
      done_nxt  = is_last && head_word.eon;
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_last_of_char = last_r;
  assign out_name_done    = done_r;

endmodule

>>> sv/macroman_to_utf8_transcoder_top.sv
// Mac OS Roman to UTF-8 transcoder, top level.
// Depends on mru8_pkg, mru8_front, mru8_queue, mru8_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one Mac OS Roman byte per word
//   plus an end-of-name flag. Output channel (out_valid/out_ready) carries
//   one UTF-8 byte per word, flagged with out_last_of_char on the last byte
//   of each character and out_name_done on the last byte of the name.
//   cfg_valid/cfg_ready writes raw mode (cfg_raw_mode); write it only while
//   the block is idle. Raw mode echoes each byte as a single word.
// Path: an input word is written into the queue when taken, and its first
//   output byte is then loaded from the queue head into the output register.
// Throughput: one output byte per cycle while the receiver holds out_ready
//   high, set by the byte-wide output register; a character is 1, 2 or 3
//   bytes (3 for code points at or above U+0800). The input side keeps taking
//   words while the two-entry queue has room.
// Reset (rst_n low, synchronous): queue empty, output invalid, raw mode off.
// Receiver stall: the output word holds; the queue fills, then in_ready
//   drops until the back end drains an entry.
module macroman_to_utf8_transcoder_top import mru8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_name_byte,
  input  logic       in_end_of_name,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_char,
  output logic       out_name_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_raw_mode
);

  // front -> queue
  logic        push;
  mru8_word_t  push_word;
  // queue -> back
  logic        pop;
  mru8_word_t  head_word;
  mru8_qstat_t qstat;

  // Classify: table lookup and UTF-8 split happen as the word is taken
  mru8_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_name_byte   (in_name_byte),
    .in_end_of_name (in_end_of_name),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_raw_mode   (cfg_raw_mode),
    .qstat          (qstat),
    .push           (push),
    .push_word      (push_word)
  );

  // Decouples input acceptance from multi-byte output
  mru8_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .qstat     (qstat)
  );

  // Serialize: one byte per cycle unless the output stalls, pops on the last byte of a character
  mru8_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_word        (head_word),
    .qstat            (qstat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_char (out_last_of_char),
    .out_name_done    (out_name_done)
  );

endmodule

>>> sv/mru8_checker.sv
// Port-level checks for the transcoder, bound to the top level.
// Depends on macroman_to_utf8_transcoder_top_defines.svh.
`include "macroman_to_utf8_transcoder_top_defines.svh"

module mru8_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last_of_char,
  input logic       out_name_done
);

  // stalled output word must hold
  `MRU8_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last_of_char) && $stable(out_name_done), "output changed while stalled")

  // end of name only on a character's last byte
  `MRU8_ASSERT_NOW(a_done_on_last, out_valid && out_name_done, out_last_of_char, "name_done without last_of_char")

  // bytes before the last of a run are lead or continuation bytes
  `MRU8_ASSERT_NOW(a_multi_high, out_valid && !out_last_of_char, out_byte[7], "non-final byte below 0x80")

  // a run continues at once with a continuation byte
  `MRU8_ASSERT_NEXT(a_cont_follows, out_valid && out_ready && !out_last_of_char, out_valid && out_byte[7:6] == 2'b10, "run not continued")

endmodule

bind macroman_to_utf8_transcoder_top mru8_checker u_mru8_checker (.*);
